// File: design/frt_pkg.sv
`timescale 1ns / 1ps
// Types, constants and codes shared by the fragment reassembly tracker.
package frt_pkg;

    localparam int ENTRIES = 8;
    localparam int AW = $clog2(ENTRIES);

    localparam logic [7:0] LIFETIME_RESET = 8'd5;
    localparam int OFFSET_SHIFT = 3;
    localparam logic [11:0] HELD_MAX = 12'hFFF;
    localparam logic [3:0] COUNT_MAX = 4'hF;

    typedef enum logic [2:0] {
        CMD_FIRST = 3'd0,
        CMD_NEXT  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_FLUSH = 3'd3
    } cmd_e;

    typedef enum logic [3:0] {
        ST_OPENED    = 4'd0,
        ST_APPENDED  = 4'd1,
        ST_COMPLETE  = 4'd2,
        ST_DUP_FIRST = 4'd3,
        ST_DUP_NEXT  = 4'd4,
        ST_ROGUE     = 4'd5,
        ST_MISSED    = 4'd6,
        ST_FULL      = 4'd7,
        ST_UNKNOWN   = 4'd8,
        ST_TICKED    = 4'd9,
        ST_FLUSHED   = 4'd10
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_e;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] sender;
        logic [15:0] tag;
        logic [10:0] dgram_size;
        logic [7:0]  frag_offset;
        logic [7:0]  frag_len;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] reassembled_length;
        logic [3:0]  discarded_count;
        logic        table_empty;
    } result_t;

    typedef struct packed {
        logic [15:0] sender;
        logic [15:0] tag;
        logic [10:0] size;
        logic [11:0] held;
        logic [7:0]  ticks;
    } entry_t;

endpackage

// File: design/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
// Reassembly context table: one entry memory walked one slot per cycle.
// One word is handled at a time, while busy is high; the next start is
// taken at the edge that ends the done cycle.
// Reset clears the valid bits and the lifetime register (to 5); entry memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
module fragment_reassembly_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  frt_pkg::item_t      item,
    output logic                done,
    output frt_pkg::result_t    result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import frt_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;

    state_e state_reg, state_next;
    item_t  item_reg, item_next;
    logic [AW:0]     rd_idx_reg, rd_idx_next;
    logic            p_vld_reg, p_vld_next;
    logic [AW-1:0]   p_idx_reg, p_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] mask_reg, mask_next;
    logic            dup_reg, dup_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   slot_reg, slot_next;
    entry_t          match_reg, match_next;
    logic            free_reg, free_next;
    logic [AW-1:0]   free_slot_reg, free_slot_next;
    logic [3:0]      count_reg, count_next;
    logic [7:0]      lifetime_reg;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;

    logic            slot_valid;
    logic            sender_hit;
    logic            key_hit;
    logic [7:0]      ticks_dec;
    logic [3:0]      count_inc;
    logic [11:0]     offset_bytes;
    logic [12:0]     held_sum;
    logic [11:0]     held_sat;
    logic [ENTRIES-1:0] valid_fin;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            lifetime_reg <= LIFETIME_RESET;
            done_reg     <= 1'b0;
            p_vld_reg    <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            p_vld_reg  <= p_vld_next;
            rd_idx_reg <= rd_idx_next;
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        p_idx_reg     <= p_idx_next;
        mask_reg      <= mask_next;
        dup_reg       <= dup_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        match_reg     <= match_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        count_reg     <= count_next;
        result_reg    <= result_next;
    end

    // compare of the slot whose read data is back this cycle
    assign slot_valid = valid_reg[p_idx_reg];
    assign sender_hit = slot_valid && (rd_data_reg.sender == item_reg.sender);
    assign key_hit    = sender_hit && (rd_data_reg.tag == item_reg.tag)
                        && (rd_data_reg.size == item_reg.dgram_size);
    assign ticks_dec  = rd_data_reg.ticks - 8'd1;
    assign count_inc  = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 4'd1;

    assign offset_bytes = {1'b0, item_reg.frag_offset, 3'b000};
    assign held_sum     = {1'b0, match_reg.held} + {5'b0, item_reg.frag_len};
    assign held_sat     = (held_sum > {1'b0, HELD_MAX}) ? HELD_MAX : held_sum[11:0];

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        rd_idx_next    = rd_idx_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = p_idx_reg;
        valid_next     = valid_reg;
        mask_next      = mask_reg;
        dup_next       = dup_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        match_next     = match_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = p_idx_reg;
        mem_wdata      = rd_data_reg;
        valid_fin      = valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    rd_idx_next = '0;
                    mask_next   = '0;
                    dup_next    = 1'b0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    count_next  = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rd_en      = (rd_idx_reg < (AW+1)'(ENTRIES));
                p_vld_next = rd_en;
                p_idx_next = rd_idx_reg[AW-1:0];
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + (AW+1)'(1);
                end
                if (p_vld_reg)
                begin
                    priority if (item_reg.cmd == CMD_FIRST)
                    begin
                        if (key_hit)
                        begin
                            dup_next = 1'b1;
                        end
                        if (sender_hit)
                        begin
                            mask_next[p_idx_reg] = 1'b1;
                            count_next = count_inc;
                        end
                        // lowest slot that is free once same-sender entries go
                        if ((!slot_valid || sender_hit) && !free_reg)
                        begin
                            free_next      = 1'b1;
                            free_slot_next = p_idx_reg;
                        end
                    end
                    else if (item_reg.cmd == CMD_NEXT)
                    begin
                        if (key_hit && !found_reg)
                        begin
                            found_next = 1'b1;
                            slot_next  = p_idx_reg;
                            match_next = rd_data_reg;
                        end
                    end
                    else if (item_reg.cmd == CMD_TICK)
                    begin
                        if (slot_valid)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.ticks = ticks_dec;
                            if (ticks_dec == 8'd0)
                            begin
                                valid_next[p_idx_reg] = 1'b0;
                                count_next = count_inc;
                            end
                        end
                    end
                    else if (item_reg.cmd == CMD_FLUSH)
                    begin
                        if (slot_valid)
                        begin
                            valid_next[p_idx_reg] = 1'b0;
                            count_next = count_inc;
                        end
                    end
                    if (!rd_en)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                result_next.reassembled_length = '0;
                result_next.discarded_count    = '0;
                priority if (item_reg.cmd == CMD_FIRST)
                begin
                    if (dup_reg)
                    begin
                        result_next.status = ST_DUP_FIRST;
                    end
                    else
                    begin
                        valid_fin = valid_reg & ~mask_reg;
                        result_next.discarded_count = count_reg;
                        if (free_reg)
                        begin
                            valid_fin[free_slot_reg] = 1'b1;
                            mem_we           = 1'b1;
                            mem_waddr        = free_slot_reg;
                            mem_wdata.sender = item_reg.sender;
                            mem_wdata.tag    = item_reg.tag;
                            mem_wdata.size   = item_reg.dgram_size;
                            mem_wdata.held   = {4'b0, item_reg.frag_len};
                            mem_wdata.ticks  = lifetime_reg;
                            result_next.status = ST_OPENED;
                        end
                        else
                        begin
                            result_next.status = ST_FULL;
                        end
                    end
                end
                else if (item_reg.cmd == CMD_NEXT)
                begin
                    priority if (!found_reg)
                    begin
                        result_next.status = ST_ROGUE;
                    end
                    else if (match_reg.held > offset_bytes)
                    begin
                        result_next.status = ST_DUP_NEXT;
                    end
                    else if (match_reg.held < offset_bytes)
                    begin
                        valid_fin[slot_reg] = 1'b0;
                        result_next.status = ST_MISSED;
                    end
                    else if (held_sat >= {1'b0, match_reg.size})
                    begin
                        valid_fin[slot_reg] = 1'b0;
                        result_next.reassembled_length = held_sat;
                        result_next.status = ST_COMPLETE;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = slot_reg;
                        mem_wdata      = match_reg;
                        mem_wdata.held = held_sat;
                        result_next.status = ST_APPENDED;
                    end
                end
                else if (item_reg.cmd == CMD_TICK)
                begin
                    result_next.discarded_count = count_reg;
                    result_next.status = ST_TICKED;
                end
                else if (item_reg.cmd == CMD_FLUSH)
                begin
                    result_next.discarded_count = count_reg;
                    result_next.status = ST_FLUSHED;
                end
                else
                begin
                    result_next.status = ST_UNKNOWN;
                end
                valid_next = valid_fin;
                result_next.table_empty = ~|valid_fin;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a word in flight");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FLUSHED) |-> result.table_empty)
        else $error("table not empty after flush");

    a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_COMPLETE) |-> (result.reassembled_length == '0))
        else $error("length reported without completion");

    a_dup_no_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DUP_FIRST) |-> (result.discarded_count == '0))
        else $error("duplicate first fragment discarded entries");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !p_vld_reg)
        else $error("finish reached with a slot compare pending");
`endif

endmodule
